FILE: rtl/imut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_pkg
// constants, lane types and the arctangent table of the tilt datapath
// ----------------------------------------------------------------------------
package imut_pkg;

	localparam int IN_W      = 16;
	localparam int NUM_W     = 17;
	localparam int GS_W      = 17;
	localparam int ANG_W     = 18;
	localparam int IVL_W     = 10;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [IVL_W-1:0] IVL_RESET = 10'd100;

	// register index codes
	localparam logic REG_INTERVAL = 1'b0;

	localparam int ROTATION_STEPS_DEF = 16;
	localparam int TAB_LEN            = 24;

	// root extraction: radicand is the sum of squares with RAD_PAD zero bits below
	localparam int RAD_W    = 32;
	localparam int RAD_PAD  = 28;
	localparam int ROOT_W   = 30;
	localparam int REM_W    = 32;
	localparam int PRESHIFT = 14;

	localparam int XY_W = 33;
	localparam int Z_W  = 32;

	// finishing arithmetic
	localparam int STEP_DIV     = 1310;
	localparam int HALF_DIV     = 655;
	localparam int ANGLE_SHIFT  = 16;
	localparam int LIMIT        = 90000;
	localparam int ZM_W         = 44;
	localparam int GM_W         = 28;
	localparam int N_W          = 44;
	localparam int T_W          = 28;
	localparam int RECIP_W      = 28;
	localparam int RECIP_SHIFT  = 38;
	localparam int PROD_W       = 55;
	localparam int Q_W          = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP  = 28'd209830464;
	localparam logic [T_W-1:0]     CLIP_T = T_W'((LIMIT + 1) * STEP_DIV);

	// atan(2^-i) in centidegrees times 2^16
	localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
		32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
		32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
		32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
		32'sd358,       32'sd179,       32'sd90,       32'sd45
	};

	typedef struct packed {
		logic [RAD_W-1:0]        rad;
		logic [REM_W-1:0]        rem;
		logic [ROOT_W-1:0]       root;
		logic signed [XY_W-1:0]  y;
		logic signed [GS_W-1:0]  gsum;
	} sq_lane_t;

	typedef struct packed {
		sq_lane_t pitch;
		sq_lane_t roll;
	} sq_word_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
		logic signed [GS_W-1:0] gsum;
	} cr_lane_t;

	typedef struct packed {
		cr_lane_t pitch;
		cr_lane_t roll;
	} cr_word_t;

endpackage

FILE: rtl/imut_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_if
// sample and result channels with valid / ready transfers
// ----------------------------------------------------------------------------
interface imut_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x_prev;
	logic signed [15:0] gyro_y_prev;
	logic signed [15:0] gyro_x_now;
	logic signed [15:0] gyro_y_now;

	modport source (output valid, accel_x, accel_y, accel_z, gyro_x_prev, gyro_y_prev,
		gyro_x_now, gyro_y_now, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, gyro_x_prev, gyro_y_prev,
		gyro_x_now, gyro_y_now, output ready);
endinterface

interface imut_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] pitch_centideg;
	logic signed [17:0] roll_centideg;
	logic               clipped;

	modport source (output valid, pitch_centideg, roll_centideg, clipped, input ready);
	modport sink (input valid, pitch_centideg, roll_centideg, clipped, output ready);
endinterface

FILE: rtl/imu_tilt_with_gyro_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_with_gyro_step
// tilt pitch and roll from one accelerometer triple plus one trapezoid gyro step
// ----------------------------------------------------------------------------
// path: front stage, square root row, rotation row, then the finishing stages
//   that end in the output register
// throughput: one sample per cycle, set by the fully pipelined row of root and
//   rotation cells; the whole row holds only when a result waits untaken
// reset: clears every stage's valid flag, interval_q returns to 100
module imu_tilt_with_gyro_step #(
	parameter int ROTATION_STEPS = imut_pkg::ROTATION_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	imut_in_if.sink                       in_ch,
	imut_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [imut_pkg::ADDR_W-1:0]   paddr,
	input  logic [imut_pkg::DATA_W-1:0]   pwdata,
	output logic [imut_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import imut_pkg::*;

	// ---- configuration register ----
	logic [IVL_W-1:0] interval_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= IVL_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_INTERVAL) begin
			interval_q <= pwdata[IVL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_INTERVAL) begin
			prdata = {{(DATA_W - IVL_W){1'b0}}, interval_q};
		end
	end

	// ---- global advance: the row moves unless the output register is stalled ----
	logic en;
	logic fin_valid;

	assign en          = !fin_valid || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = fin_valid;

	// ---- front stage: squares, numerators and gyro sums ----
	logic                    v_s1;
	sq_word_t                w_s1;
	logic signed [NUM_W-1:0] num_p;
	logic signed [NUM_W-1:0] num_r;
	logic signed [2*IN_W-1:0] sq_ax;
	logic signed [2*IN_W-1:0] sq_ay;
	logic signed [2*IN_W-1:0] sq_az;

	assign num_p = -NUM_W'(in_ch.accel_x);   // pitch numerator is minus ax
	assign num_r = NUM_W'(in_ch.accel_y);
	assign sq_ax = (2*IN_W)'(in_ch.accel_x) * (2*IN_W)'(in_ch.accel_x);
	assign sq_ay = (2*IN_W)'(in_ch.accel_y) * (2*IN_W)'(in_ch.accel_y);
	assign sq_az = (2*IN_W)'(in_ch.accel_z) * (2*IN_W)'(in_ch.accel_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1.pitch.rad  <= RAD_W'(sq_ay) + RAD_W'(sq_az);
			w_s1.pitch.rem  <= '0;
			w_s1.pitch.root <= '0;
			w_s1.pitch.y    <= XY_W'($signed({num_p, {PRESHIFT{1'b0}}}));
			w_s1.pitch.gsum <= GS_W'(in_ch.gyro_y_prev) + GS_W'(in_ch.gyro_y_now);
			w_s1.roll.rad   <= RAD_W'(sq_ax) + RAD_W'(sq_az);
			w_s1.roll.rem   <= '0;
			w_s1.roll.root  <= '0;
			w_s1.roll.y     <= XY_W'($signed({num_r, {PRESHIFT{1'b0}}}));
			w_s1.roll.gsum  <= GS_W'(in_ch.gyro_x_prev) + GS_W'(in_ch.gyro_x_now);
		end
	end

	// ---- square root row: one result bit per cell ----
	logic     sq_v [ROOT_W+1];
	sq_word_t sq_w [ROOT_W+1];

	assign sq_v[0] = v_s1;
	assign sq_w[0] = w_s1;

	genvar g;
	generate
		for (g = 0; g < ROOT_W; g++) begin : g_sqrt
			imut_sqrt_cell #(.STEP(g)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (sq_v[g]),
				.in_word  (sq_w[g]),
				.out_valid(sq_v[g+1]),
				.out_word (sq_w[g+1])
			);
		end
	endgenerate

	// ---- hand-over: root becomes the x operand, zero vector marked ----
	logic     cr_v [ROTATION_STEPS+1];
	cr_word_t cr_w [ROTATION_STEPS+1];

	function automatic cr_lane_t to_cordic(input sq_lane_t a);
		cr_lane_t b;
		b.x    = $signed({{(XY_W - ROOT_W){1'b0}}, a.root});
		b.y    = a.y;
		b.z    = '0;
		b.zero = (a.root == '0) && (a.y == '0);
		b.gsum = a.gsum;
		return b;
	endfunction

	assign cr_v[0]       = sq_v[ROOT_W];
	assign cr_w[0].pitch = to_cordic(sq_w[ROOT_W].pitch);
	assign cr_w[0].roll  = to_cordic(sq_w[ROOT_W].roll);

	// ---- rotation row: one vectoring step per cell ----
	generate
		for (g = 0; g < ROTATION_STEPS; g++) begin : g_cordic
			imut_cordic_cell #(.STEP(g)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (cr_v[g]),
				.in_word  (cr_w[g]),
				.out_valid(cr_v[g+1]),
				.out_word (cr_w[g+1])
			);
		end
	endgenerate

	// ---- gyro step, rounding and saturation; last stage is the output register ----
	imut_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cr_v[ROTATION_STEPS]),
		.in_word  (cr_w[ROTATION_STEPS]),
		.interval (interval_q),
		.out_valid(fin_valid),
		.pitch    (out_ch.pitch_centideg),
		.roll     (out_ch.roll_centideg),
		.clipped  (out_ch.clipped)
	);

endmodule

FILE: rtl/imut_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_sqrt_cell
// one result bit of the square root for both lanes
// ----------------------------------------------------------------------------
module imut_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  imut_pkg::sq_word_t in_word,
	output logic               out_valid,
	output imut_pkg::sq_word_t out_word
);
	import imut_pkg::*;

	localparam int J  = ROOT_W - 1 - STEP;
	localparam int LO = 2 * J - RAD_PAD;

	logic [1:0] pair_p;
	logic [1:0] pair_r;
	sq_word_t   nxt;

	generate
		if (LO >= 0) begin : g_bits
			assign pair_p = in_word.pitch.rad[LO +: 2];
			assign pair_r = in_word.roll.rad[LO +: 2];
		end else begin : g_pad
			assign pair_p = 2'b00;
			assign pair_r = 2'b00;
		end
	endgenerate

	function automatic sq_lane_t sq_step(input sq_lane_t a, input logic [1:0] pair);
		sq_lane_t         b;
		logic [REM_W+1:0] remn;
		logic [REM_W+1:0] trial;
		b     = a;
		remn  = {a.rem, pair};
		trial = {{(REM_W - ROOT_W){1'b0}}, a.root, 2'b01};
		if (remn >= trial) begin
			b.rem  = REM_W'(remn - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = REM_W'(remn);
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	always_comb begin
		nxt.pitch = sq_step(in_word.pitch, pair_p);
		nxt.roll  = sq_step(in_word.roll, pair_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule

FILE: rtl/imut_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_cordic_cell
// one vectoring rotation for both lanes
// ----------------------------------------------------------------------------
module imut_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  imut_pkg::cr_word_t in_word,
	output logic               out_valid,
	output imut_pkg::cr_word_t out_word
);
	import imut_pkg::*;

	cr_word_t nxt;

	function automatic cr_lane_t cr_step(input cr_lane_t a);
		cr_lane_t               b;
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		b  = a;
		xs = a.x >>> STEP;
		ys = a.y >>> STEP;
		if (!a.y[XY_W-1]) begin
			b.x = a.x + ys;
			b.y = a.y - xs;
			b.z = a.z + ATAN_TAB[STEP];
		end else begin
			b.x = a.x - ys;
			b.y = a.y + xs;
			b.z = a.z - ATAN_TAB[STEP];
		end
		return b;
	endfunction

	always_comb begin
		nxt.pitch = cr_step(in_word.pitch);
		nxt.roll  = cr_step(in_word.roll);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= nxt;
		end
	end

endmodule

FILE: rtl/imut_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_finish
// gyro step, rounding division by 65536*1310 and saturation
// ----------------------------------------------------------------------------
module imut_finish (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  imut_pkg::cr_word_t            in_word,
	input  logic [imut_pkg::IVL_W-1:0]    interval,
	output logic                          out_valid,
	output logic signed [imut_pkg::ANG_W-1:0] pitch,
	output logic signed [imut_pkg::ANG_W-1:0] roll,
	output logic                          clipped
);
	import imut_pkg::*;

	localparam logic signed [11:0] DIV_C = 12'(STEP_DIV);

	logic [3:0] v_q;

	logic signed [Z_W-1:0]  z_in  [2];
	logic signed [GS_W-1:0] g_in  [2];

	logic signed [ZM_W-1:0] zm_s1 [2];
	logic signed [GM_W-1:0] gm_s1 [2];
	logic signed [N_W-1:0]  n_s2  [2];
	logic [T_W-1:0]         t_s3  [2];
	logic                   neg_s3 [2];
	logic                   clip_s3 [2];
	logic [PROD_W-1:0]      prod_s4 [2];
	logic                   neg_s4 [2];
	logic                   clip_s4 [2];
	logic signed [ANG_W-1:0] res   [2];

	logic signed [IVL_W:0]  ivl_s;
	logic [N_W-1:0]         mag   [2];

	assign ivl_s = $signed({1'b0, interval});

	// zero vector reads as zero tilt
	assign z_in[0] = in_word.pitch.zero ? '0 : in_word.pitch.z;
	assign z_in[1] = in_word.roll.zero ? '0 : in_word.roll.z;
	assign g_in[0] = in_word.pitch.gsum;
	assign g_in[1] = in_word.roll.gsum;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			mag[i] = n_s2[i][N_W-1] ? N_W'(-n_s2[i]) : N_W'(n_s2[i]);
		end
	end

	always_comb begin
		logic [ANG_W-1:0] m;
		for (int i = 0; i < 2; i++) begin
			m = clip_s4[i] ? ANG_W'(LIMIT)
				: {{(ANG_W - Q_W){1'b0}}, prod_s4[i][PROD_W-1:RECIP_SHIFT]};
			res[i] = neg_s4[i] ? $signed(-m) : $signed(m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q       <= {v_q[2:0], in_valid};
			out_valid <= v_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				zm_s1[i]   <= ZM_W'(z_in[i] * DIV_C);
				gm_s1[i]   <= GM_W'(g_in[i] * ivl_s);
				n_s2[i]    <= zm_s1[i] + (N_W'(gm_s1[i]) <<< ANGLE_SHIFT);
				t_s3[i]    <= T_W'(mag[i][N_W-2:ANGLE_SHIFT]) + T_W'(HALF_DIV);
				neg_s3[i]  <= n_s2[i][N_W-1];
				clip_s3[i] <= (T_W'(mag[i][N_W-2:ANGLE_SHIFT]) + T_W'(HALF_DIV)) >= CLIP_T;
				prod_s4[i] <= PROD_W'(t_s3[i][T_W-2:0] * RECIP);
				neg_s4[i]  <= neg_s3[i];
				clip_s4[i] <= clip_s3[i];
			end
			pitch   <= res[0];
			roll    <= res[1];
			clipped <= clip_s4[0] | clip_s4[1];
		end
	end

endmodule

FILE: rtl/imut_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imut_checker
// port-level checks on the tilt block, bound to the top level
// ----------------------------------------------------------------------------
module imut_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [imut_pkg::ANG_W-1:0] pitch,
	input logic signed [imut_pkg::ANG_W-1:0] roll,
	input logic                              clipped
);
	import imut_pkg::*;

	localparam logic signed [ANG_W-1:0] POS = ANG_W'(LIMIT);
	localparam logic signed [ANG_W-1:0] NEG = -ANG_W'(LIMIT);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an empty output register never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch <= POS && pitch >= NEG && roll <= POS && roll >= NEG))
		else $error("angle beyond saturation limit");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (pitch == POS || pitch == NEG || roll == POS || roll == NEG))
		else $error("clip flag without a clamped angle");

endmodule

bind imu_tilt_with_gyro_step imut_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.pitch    (out_ch.pitch_centideg),
	.roll     (out_ch.roll_centideg),
	.clipped  (out_ch.clipped)
);
